[design/tga_image_stream_decoder_defines.svh]
// Assertion macros for the TGA stream decoder.
// Each check is disabled while rst is high and sampled on the rising edge of clk.
`ifndef TGA_IMAGE_STREAM_DECODER_DEFINES_SVH
`define TGA_IMAGE_STREAM_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

`define TGAD_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tgad: invariant violated");

`define TGAD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tgad: same-cycle check failed");

`define TGAD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tgad: next-cycle check failed");

`else

`define TGAD_ASSERT_NOW(label, cond)
`define TGAD_ASSERT_IMPL(label, ante, cons)
`define TGAD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[design/tgad_pkg.sv]
package tgad_pkg;

  // result kinds (tuser on the master side)
  typedef enum logic [1:0] {
    KIND_PIXEL    = 2'd0,
    KIND_HEADER   = 2'd1,
    KIND_BAD_TYPE = 2'd2,
    KIND_BAD_SIZE = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    PH_PREFIX = 5'b00001,
    PH_SIZE   = 5'b00010,
    PH_PACKET = 5'b00100,
    PH_PIXEL  = 5'b01000,
    PH_IDLE   = 5'b10000
  } phase_t;

  // header byte positions
  localparam logic [4:0] HDR_TYPE_IDX   = 5'd2;
  localparam logic [4:0] HDR_PREFIX_END = 5'd11;
  localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
  localparam logic [4:0] HDR_DEPTH      = 5'd16;
  localparam logic [4:0] HDR_DESC       = 5'd17;

  localparam logic [7:0]  TYPE_RAW = 8'd2;
  localparam logic [7:0]  TYPE_RLE = 8'd10;
  localparam logic [31:0] DEPTH_24 = 32'd24;
  localparam logic [31:0] DEPTH_32 = 32'd32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       sof;
  } in_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_count;
    logic        last_pixel;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
  } res_t;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  header_index;
    logic        is_compressed;
    logic [15:0] width_held;
    logic [15:0] height_held;
    logic        four_bytes;
    logic [31:0] pixels_left;
    logic [7:0]  packet_left;
    logic        packet_is_run;
    logic [31:0] pixel_bytes;
    logic [1:0]  pixel_byte_index;
  } state_t;

  localparam state_t ST_RESET = '{
    phase:            PH_PREFIX,
    header_index:     5'd0,
    is_compressed:    1'b0,
    width_held:       16'd0,
    height_held:      16'd0,
    four_bytes:       1'b0,
    pixels_left:      32'd0,
    packet_left:      8'd0,
    packet_is_run:    1'b0,
    pixel_bytes:      32'd0,
    pixel_byte_index: 2'd0
  };

endpackage

[design/tga_image_stream_decoder.sv]
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tdata: data_byte; tuser: start_of_file
// m_*       out  m_tvalid/m_tready    tdata: pixel/header fields; tuser: kind;
//                                     tlast: last_pixel
//
// One word per cycle sustained while m_tready stays high. A word is parsed while it
// sits in the input register; the state update and the result load share the edge
// on which it leaves that register, after which the result is offered. It then
// sits in the output register until taken.
// rst (synchronous) returns the parser to the header prefix, as if the next
// word carried start_of_file; both stages empty.
// A stalled m_tready backs up through the output register, then the input
// register; s_tready drops only when both are full.
`include "tga_image_stream_decoder_defines.svh"

module tga_image_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] start_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] repeat_count,
  // [55:40] image_width, [71:56] image_height, [72] has_alpha, [79:73] zero
  output logic [79:0] m_tdata,
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast    // last_pixel
);
  import tgad_pkg::*;

  in_t  s_item;
  in_t  item;
  logic in_valid;
  logic out_free;
  logic step;
  logic res_valid;
  res_t res;
  res_t m_res;

  assign s_item.data_byte = s_tdata;
  assign s_item.sof       = s_tuser;

  // the parsed word moves on only if the result register can take its output
  assign step = in_valid && out_free;

  tgad_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_tvalid),
    .s_ready  (s_tready),
    .s_item   (s_item),
    .take     (step),
    .in_valid (in_valid),
    .item     (item)
  );

  tgad_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  tgad_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (step && res_valid),
    .res     (res),
    .free    (out_free),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_res   (m_res)
  );

  assign m_tdata = {7'd0, m_res.has_alpha, m_res.image_height, m_res.image_width,
                    m_res.repeat_count, m_res.alpha, m_res.blue, m_res.green,
                    m_res.red};
  assign m_tuser = m_res.kind;
  assign m_tlast = m_res.last_pixel;

  // input side stalls only behind a held result
  `TGAD_ASSERT_IMPL(a_stall_cause, !s_tready, m_tvalid && !m_tready)
  // a produced result is presented on the next cycle
  `TGAD_ASSERT_NEXT(a_result_shown, step && res_valid, m_tvalid)
  // a pixel result never stands for zero pixels
  `TGAD_ASSERT_NOW(a_rep_nonzero, !(m_tvalid && m_tuser == KIND_PIXEL) || m_tdata[39:32] != 8'd0)

endmodule

[design/tgad_in_reg.sv]
module tgad_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_valid,
  output logic          s_ready,
  input  tgad_pkg::in_t s_item,
  input  logic          take,
  output logic          in_valid,
  output tgad_pkg::in_t item
);
  import tgad_pkg::*;

  assign s_ready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_ready) begin
      in_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule

[design/tgad_parser.sv]
module tgad_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  tgad_pkg::in_t  item,
  output logic           res_valid,
  output tgad_pkg::res_t res
);
  import tgad_pkg::*;

  state_t      st;
  state_t      cur;
  state_t      st_next;
  logic [7:0]  b;
  logic        ok;
  logic        bad;
  logic [31:0] word;
  logic        pix_done;
  logic [7:0]  rep;
  logic [31:0] remain;

  assign b   = item.data_byte;
  // start of file restarts the parse on this very byte
  assign cur = item.sof ? ST_RESET : st;

  always_comb begin
    st_next   = cur;
    res_valid = 1'b0;
    res       = '0;
    ok        = 1'b0;
    bad       = 1'b0;
    word      = cur.pixel_bytes | ({24'd0, b} << {cur.pixel_byte_index, 3'b000});
    pix_done  = cur.four_bytes ? (cur.pixel_byte_index == 2'd3)
                               : (cur.pixel_byte_index == 2'd2);
    rep       = 8'd1;
    remain    = cur.pixels_left;
    case (cur.phase)
      PH_PREFIX: begin
        if (cur.header_index == HDR_TYPE_IDX) begin
          ok = b inside {TYPE_RAW, TYPE_RLE};
          st_next.is_compressed = (b == TYPE_RLE);
        end else begin
          ok = (b == 8'd0);
        end
        if (!ok) begin
          res_valid     = 1'b1;
          res.kind      = KIND_BAD_TYPE;
          st_next.phase = PH_IDLE;
        end else begin
          st_next.header_index = cur.header_index + 5'd1;
          if (cur.header_index == HDR_PREFIX_END) st_next.phase = PH_SIZE;
        end
      end
      PH_SIZE: begin
        case (cur.header_index)
          HDR_WIDTH_LO:  st_next.width_held  = {8'd0, b};
          HDR_WIDTH_HI:  st_next.width_held  = {b, cur.width_held[7:0]};
          HDR_HEIGHT_LO: st_next.height_held = {8'd0, b};
          HDR_HEIGHT_HI: st_next.height_held = {b, cur.height_held[7:0]};
          HDR_DEPTH:     st_next.pixel_bytes = {24'd0, b};
          default: ;
        endcase
        if (cur.header_index < HDR_DESC) begin
          st_next.header_index = cur.header_index + 5'd1;
        end else begin
          res_valid        = 1'b1;
          res.image_width  = cur.width_held;
          res.image_height = cur.height_held;
          bad = (cur.width_held == 16'd0) || (cur.height_held == 16'd0) ||
                !(cur.pixel_bytes inside {DEPTH_24, DEPTH_32});
          if (bad) begin
            res.kind      = KIND_BAD_SIZE;
            st_next.phase = PH_IDLE;
          end else begin
            res.kind                 = KIND_HEADER;
            res.has_alpha            = (cur.pixel_bytes == DEPTH_32);
            st_next.four_bytes       = (cur.pixel_bytes == DEPTH_32);
            st_next.pixels_left      = {16'd0, cur.width_held} * {16'd0, cur.height_held};
            st_next.pixel_bytes      = 32'd0;
            st_next.pixel_byte_index = 2'd0;
            st_next.packet_left      = 8'd0;
            st_next.packet_is_run    = 1'b0;
            st_next.phase            = cur.is_compressed ? PH_PACKET : PH_PIXEL;
          end
        end
      end
      PH_PACKET: begin
        // raw: low7+1 pixels; run: header-127 = low7+1 copies
        st_next.packet_is_run    = b[7];
        st_next.packet_left      = {1'b0, b[6:0]} + 8'd1;
        st_next.pixel_bytes      = 32'd0;
        st_next.pixel_byte_index = 2'd0;
        st_next.phase            = PH_PIXEL;
      end
      PH_PIXEL: begin
        if (!pix_done) begin
          st_next.pixel_bytes      = word;
          st_next.pixel_byte_index = cur.pixel_byte_index + 2'd1;
        end else begin
          if (cur.is_compressed && cur.packet_is_run) begin
            // clamp a run that overshoots the image
            rep = ({24'd0, cur.packet_left} > cur.pixels_left) ? cur.pixels_left[7:0]
                                                               : cur.packet_left;
            st_next.packet_left = 8'd0;
          end else if (cur.is_compressed && cur.packet_left != 8'd0) begin
            st_next.packet_left = cur.packet_left - 8'd1;
          end
          remain                   = cur.pixels_left - {24'd0, rep};
          st_next.pixels_left      = remain;
          st_next.pixel_bytes      = 32'd0;
          st_next.pixel_byte_index = 2'd0;
          res_valid                = 1'b1;
          res.kind                 = KIND_PIXEL;
          res.red                  = word[23:16];
          res.green                = word[15:8];
          res.blue                 = word[7:0];
          res.alpha                = cur.four_bytes ? word[31:24] : 8'd0;
          res.repeat_count         = rep;
          res.last_pixel           = (remain == 32'd0);
          res.has_alpha            = cur.four_bytes;
          if (remain == 32'd0) begin
            st_next.phase = PH_IDLE;
          end else if (cur.is_compressed && st_next.packet_left == 8'd0) begin
            st_next.phase = PH_PACKET;
          end
        end
      end
      PH_IDLE: ;
      default: st_next.phase = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (step) begin
      st <= st_next;
    end
  end

endmodule

[design/tgad_out_reg.sv]
module tgad_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  tgad_pkg::res_t res,
  output logic           free,
  output logic           m_valid,
  input  logic           m_ready,
  output tgad_pkg::res_t m_res
);
  import tgad_pkg::*;

  assign free = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_res <= res;
    end
  end

endmodule

[dv/tb_top.sv]
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tgad_pkg::*;

  localparam int RANDOM_BYTES = 1200;   // parsed bytes in the random part
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
  localparam int NO_FAULT     = 31;     // header position that never exists
  localparam int DRAIN_CYCLES = 8;      // two-stage pipe, plus margin

  // Tracks the decoder state per accepted byte and holds the words it must emit.
  class tga_decode_board;
    phase_t      ph;
    logic [4:0]  hdr_pos;
    logic        rle_mode;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic        rgba_mode;
    logic [31:0] px_remaining;
    logic [7:0]  pkt_count;
    logic        pkt_repeat;
    logic [31:0] px_acc;
    logic [1:0]  px_lane;

    res_t        pending_words[$];
    int          errors;
    int          parsed;
    int          ignored;
    int          n_headers;
    int          n_bad_type;
    int          n_bad_size;
    int          n_pixels;
    int          n_clamped;

    function new();
      clear_parser();
      errors = 0;
      parsed = 0;
      ignored = 0;
      n_headers = 0;
      n_bad_type = 0;
      n_bad_size = 0;
      n_pixels = 0;
      n_clamped = 0;
    endfunction

    function void clear_parser();
      ph = PH_PREFIX;
      hdr_pos = '0;
      rle_mode = 1'b0;
      img_w = '0;
      img_h = '0;
      rgba_mode = 1'b0;
      px_remaining = '0;
      pkt_count = '0;
      pkt_repeat = 1'b0;
      px_acc = '0;
      px_lane = '0;
    endfunction

    // one accepted input word: advance the parser, queue any result
    function void take_byte(logic [7:0] b, logic sof);
      res_t        r;
      logic        ok;
      logic [31:0] rep;
      logic [1:0]  top_lane;
      r = '0;
      if (sof) clear_parser();
      if (ph == PH_IDLE) begin
        ignored++;
        return;
      end
      parsed++;
      case (ph)
        PH_PREFIX: begin
          if (hdr_pos == HDR_TYPE_IDX) begin
            ok = (b == TYPE_RAW) || (b == TYPE_RLE);
            rle_mode = (b == TYPE_RLE);
          end else begin
            ok = (b == 8'd0);
          end
          if (!ok) begin
            r.kind = KIND_BAD_TYPE;
            ph = PH_IDLE;
            n_bad_type++;
            pending_words.push_back(r);
          end else begin
            hdr_pos++;
            if (hdr_pos > HDR_PREFIX_END) ph = PH_SIZE;
          end
        end
        PH_SIZE: begin
          case (hdr_pos)
            HDR_WIDTH_LO:  img_w = {8'd0, b};
            HDR_WIDTH_HI:  img_w[15:8] = b;
            HDR_HEIGHT_LO: img_h = {8'd0, b};
            HDR_HEIGHT_HI: img_h[15:8] = b;
            HDR_DEPTH:     px_acc = {24'd0, b};
            default: ;
          endcase
          if (hdr_pos < HDR_DESC) begin
            hdr_pos++;
          end else begin
            r.image_width = img_w;
            r.image_height = img_h;
            if (img_w == 16'd0 || img_h == 16'd0 ||
                (px_acc != DEPTH_24 && px_acc != DEPTH_32)) begin
              r.kind = KIND_BAD_SIZE;
              ph = PH_IDLE;
              n_bad_size++;
            end else begin
              rgba_mode = (px_acc == DEPTH_32);
              r.kind = KIND_HEADER;
              r.has_alpha = rgba_mode;
              px_remaining = 32'(img_w) * 32'(img_h);
              px_acc = '0;
              px_lane = '0;
              pkt_count = '0;
              pkt_repeat = 1'b0;
              ph = rle_mode ? PH_PACKET : PH_PIXEL;
              n_headers++;
            end
            pending_words.push_back(r);
          end
        end
        PH_PACKET: begin
          pkt_repeat = b[7];
          pkt_count = b[7] ? 8'(b - 8'd127) : 8'(b + 8'd1);
          px_acc = '0;
          px_lane = '0;
          ph = PH_PIXEL;
        end
        PH_PIXEL: begin
          top_lane = rgba_mode ? 2'd3 : 2'd2;
          px_acc |= 32'(b) << (8 * px_lane);
          if (px_lane < top_lane) begin
            px_lane++;
          end else begin
            if (rle_mode && pkt_repeat) begin
              rep = 32'(pkt_count);
              if (rep > px_remaining) begin
                rep = px_remaining;
                n_clamped++;
              end
              pkt_count = '0;
            end else begin
              rep = 32'd1;
              if (rle_mode && pkt_count != 8'd0) pkt_count--;
            end
            px_remaining -= rep;
            r.kind = KIND_PIXEL;
            r.red = px_acc[23:16];
            r.green = px_acc[15:8];
            r.blue = px_acc[7:0];
            r.alpha = rgba_mode ? px_acc[31:24] : 8'd0;
            r.repeat_count = rep[7:0];
            r.last_pixel = (px_remaining == 32'd0);
            r.has_alpha = rgba_mode;
            px_acc = '0;
            px_lane = '0;
            if (px_remaining == 32'd0) ph = PH_IDLE;
            else if (rle_mode && pkt_count == 8'd0) ph = PH_PACKET;
            n_pixels++;
            pending_words.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, want);
      errors++;
    endtask

    task check_word(logic [1:0] kind_bits, logic [79:0] word, logic last);
      res_t e;
      if (pending_words.size() == 0) begin
        report("unexpected word kind", 32'(kind_bits), 32'd0);
        return;
      end
      e = pending_words.pop_front();
      if (kind_bits != e.kind)             report("kind", kind_bits, e.kind);
      if (word[7:0] != e.red)              report("red", word[7:0], e.red);
      if (word[15:8] != e.green)           report("green", word[15:8], e.green);
      if (word[23:16] != e.blue)           report("blue", word[23:16], e.blue);
      if (word[31:24] != e.alpha)          report("alpha", word[31:24], e.alpha);
      if (word[39:32] != e.repeat_count)   report("repeat_count", word[39:32], e.repeat_count);
      if (word[55:40] != e.image_width)    report("image_width", word[55:40], e.image_width);
      if (word[71:56] != e.image_height)   report("image_height", word[71:56], e.image_height);
      if (word[72] != e.has_alpha)         report("has_alpha", word[72], e.has_alpha);
      if (word[79:73] != 7'd0)             report("tdata pad", word[79:73], 32'd0);
      if (last != e.last_pixel)            report("tlast", last, e.last_pixel);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;    // [7:0] data_byte
  logic        s_tuser = 1'b0;    // [0] start_of_file
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] repeat_count,
  // [55:40] image_width, [71:56] image_height, [72] has_alpha, [79:73] zero
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;           // [1:0] kind
  logic        m_tlast;           // last_pixel

  tga_decode_board sb = new();

  int idle_pct = 0;   // sender gap odds, percent
  int stall_pct = 0;  // receiver stall odds, percent
  bit hold_go = 1'b0;
  int cycles = 0;

  tga_image_stream_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycles,
               sb.pending_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here so the
  // pipe backs up all the way to s_tready while the sender keeps pushing.
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: values read right after the edge are the ones the DUT saw.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tuser, m_tdata, m_tlast);
  end

  // One input word; returns on the edge where it was taken.
  task automatic send_byte(input logic [7:0] d, input logic sof);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= sof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_byte(d, sof);
  endtask

  task automatic send_pixel(input bit four);
    repeat (four ? 4 : 3) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // 18-byte header; fault_at swaps in fault_val at that position
  task automatic send_header(input logic [7:0] ftype, input logic [15:0] w,
                             input logic [15:0] h, input logic [7:0] depth,
                             input bit mark, input int fault_at,
                             input logic [7:0] fault_val);
    logic [4:0] pos;
    logic [7:0] d;
    for (pos = 5'd0; pos <= HDR_DESC; pos++) begin
      case (pos)
        HDR_TYPE_IDX:  d = ftype;
        HDR_WIDTH_LO:  d = w[7:0];
        HDR_WIDTH_HI:  d = w[15:8];
        HDR_HEIGHT_LO: d = h[7:0];
        HDR_HEIGHT_HI: d = h[15:8];
        HDR_DEPTH:     d = depth;
        HDR_DESC:      d = 8'($urandom_range(0, 255));
        default:       d = 8'd0;
      endcase
      if (int'(pos) == fault_at) d = fault_val;
      send_byte(d, mark && pos == 5'd0);
    end
  endtask

  // Packets covering npix pixels; short raw packets sometimes overrun the image.
  task automatic send_rle_body(input bit four, input int npix);
    int         left;
    int         count;
    int         n;
    logic [7:0] pkt;
    left = npix;
    while (left > 0) begin
      case ($urandom_range(0, 9))
        0:          pkt = 8'($urandom_range(0, 255));
        1, 2, 3, 4: pkt = 8'($urandom_range(0, 7));
        default:    pkt = 8'($urandom_range(128, 135));
      endcase
      send_byte(pkt, 1'b0);
      if (pkt[7]) begin
        count = int'(pkt) - 127;
        send_pixel(four);
      end else begin
        count = int'(pkt) + 1;
        n = (count < left) ? count : left;
        if (count <= 8 && $urandom_range(0, 3) == 0) n = count;
        repeat (n) send_pixel(four);
      end
      left -= (count < left) ? count : left;
    end
  endtask

  task automatic send_image(input bit rle, input bit four, input logic [15:0] w,
                            input logic [15:0] h, input int body_pix);
    send_header(rle ? TYPE_RLE : TYPE_RAW, w, h, four ? 8'(DEPTH_32) : 8'(DEPTH_24),
                1'b1, NO_FAULT, 8'd0);
    if (rle) send_rle_body(four, body_pix);
    else repeat (body_pix) send_pixel(four);
  endtask

  task automatic random_file();
    int          pick;
    bit          rle;
    bit          four;
    logic [15:0] w;
    logic [15:0] h;
    int          npix;
    logic [7:0]  depth;
    pick = $urandom_range(0, 99);
    rle = 1'($urandom_range(0, 1));
    four = 1'($urandom_range(0, 1));
    w = 16'($urandom_range(1, 6));
    h = 16'($urandom_range(1, 4));
    npix = int'(w) * int'(h);
    if (pick < 70) begin
      // well-formed image, now and then cut short by the next file
      send_image(rle, four, w, h,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, npix - 1) : npix);
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 75) begin
      // large image: a few pixels, then abandoned
      send_image(rle, four, 16'($urandom_range(7, 65535)), 16'($urandom_range(1, 65535)),
                 $urandom_range(1, 4));
    end else if (pick < 85) begin
      // one header byte replaced by junk, then some pixel bytes
      send_header(rle ? TYPE_RLE : TYPE_RAW, w, h, four ? 8'(DEPTH_32) : 8'(DEPTH_24),
                  1'b1, $urandom_range(0, 17), 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 3)) send_pixel(four);
    end else if (pick < 95) begin
      // size or depth out of range
      depth = four ? 8'(DEPTH_32) : 8'(DEPTH_24);
      case ($urandom_range(0, 2))
        0:       w = 16'd0;
        1:       h = 16'd0;
        default: depth = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 1) == 1) w[15:8] = 8'($urandom_range(0, 255));
      send_header(rle ? TYPE_RLE : TYPE_RAW, w, h, depth, 1'b1, NO_FAULT, 8'd0);
    end else begin
      // plain noise
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      repeat ($urandom_range(1, 6))
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0));
    end
  endtask

  initial begin
    int start_parsed;
    int k;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed files.
    // First file without start_of_file: reset alone must arm the parser.
    send_header(TYPE_RAW, 16'd1, 16'd1, 8'(DEPTH_24), 1'b0, NO_FAULT, 8'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hA5, 1'b0);          // idle after the image, ignored
    // longest run packet, clamped to the 6 pixels of a 2x3 image
    send_image(1'b1, 1'b1, 16'd2, 16'd3, 0);
    send_byte(8'hFF, 1'b0);
    send_pixel(1'b1);
    // longest raw packet running past a 2x1 image
    send_image(1'b1, 1'b0, 16'd2, 16'd1, 0);
    send_byte(8'h7F, 1'b0);
    repeat (3) send_pixel(1'b0);
    // shortest raw packet, shortest run, then a run clamped to one pixel
    send_image(1'b1, 1'b0, 16'd3, 16'd1, 0);
    send_byte(8'h00, 1'b0);
    send_pixel(1'b0);
    send_byte(8'h80, 1'b0);
    send_pixel(1'b0);
    send_byte(8'h81, 1'b0);
    send_pixel(1'b0);
    // prefix mismatches: first byte, type byte, last prefix byte
    send_header(TYPE_RAW, 16'd1, 16'd1, 8'(DEPTH_24), 1'b1, 0, 8'hFF);
    send_header(TYPE_RAW, 16'd1, 16'd1, 8'(DEPTH_24), 1'b1, int'(HDR_TYPE_IDX), 8'd3);
    send_header(TYPE_RAW, 16'd1, 16'd1, 8'(DEPTH_24), 1'b1, int'(HDR_PREFIX_END), 8'h80);
    // size and depth rejections
    send_header(TYPE_RAW, 16'd0, 16'd5, 8'(DEPTH_24), 1'b1, NO_FAULT, 8'd0);
    send_header(TYPE_RLE, 16'd5, 16'd0, 8'(DEPTH_32), 1'b1, NO_FAULT, 8'd0);
    send_header(TYPE_RAW, 16'd4, 16'd4, 8'd16, 1'b1, NO_FAULT, 8'd0);
    send_header(TYPE_RAW, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, NO_FAULT, 8'd0);
    // largest image: one full run, then a restart in mid-file
    send_image(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 0);
    send_byte(8'hFF, 1'b0);
    send_pixel(1'b1);
    send_byte(8'h05, 1'b0);
    send_byte(8'h12, 1'b0);
    send_image(1'b0, 1'b1, 16'd1, 16'd2, 2);

    // Random files over four idling phases; the long hold-off opens the first.
    start_parsed = sb.parsed;
    for (k = 0; k < 4; k++) begin
      case (k)
        0: begin idle_pct = 0;  stall_pct = 0;  hold_go = 1'b1; end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      while (sb.parsed < start_parsed + (k + 1) * RANDOM_BYTES / 4) random_file();
    end

    s_tvalid <= 1'b0;
    stall_pct = 0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d bytes parsed, %0d ignored; %0d headers taken, %0d bad type, %0d bad size",
             sb.parsed, sb.ignored, sb.n_headers, sb.n_bad_type, sb.n_bad_size);
    $display("run: %0d pixel words, %0d runs clamped at image end, %0d cycles",
             sb.n_pixels, sb.n_clamped, cycles);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
